// ----- rtl/sedx_pkg.sv -----
`default_nettype none
package sedx_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VW        = 39;
  localparam int IW        = 31;
  localparam int CW        = 17;
  localparam int OW        = 32;
  localparam int NREG      = 8;
  localparam int REG_IW    = 3;

  typedef logic [VW-1:0] q_t;

  typedef struct packed {
    logic sat;
    q_t   v;
  } qs_t;

  typedef enum logic [REG_IW-1:0] {
    REG_ERO_BASE   = 3'd0,
    REG_DEP_STRESS = 3'd1,
    REG_RHO        = 3'd2,
    REG_KNEE       = 3'd3,
    REG_SLOPE      = 3'd4,
    REG_ERO_RATIO  = 3'd5,
    REG_PICKUP     = 3'd6,
    REG_UCR        = 3'd7
  } reg_idx_t;

  localparam q_t LIM     = {VW{1'b1}};
  localparam q_t Q_ONE   = q_t'(64'd1 << FRAC_BITS);
  localparam q_t Q_5_4   = q_t'(((64'd5 << FRAC_BITS) + 64'd2) / 64'd4);
  localparam q_t Q_19_4  = q_t'(((64'd19 << FRAC_BITS) + 64'd2) / 64'd4);
  localparam q_t Q_434   = q_t'(((64'd434 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam q_t Q_5975  = q_t'(((64'd5975 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam q_t Q_2888  = q_t'(((64'd2888 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam q_t Q_3_10  = q_t'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);

  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = VW / DIV_STEP;
  localparam int DIV_LAT    = DIV_STAGES + 1;

  localparam int SQ_IW     = VW + FRAC_BITS;
  localparam int SQ_STEP   = 2;
  localparam int SQ_STAGES = (SQ_IW + 2 * SQ_STEP - 1) / (2 * SQ_STEP);
  localparam int SQ_RW     = SQ_STAGES * SQ_STEP;
  localparam int SQ_LAT    = SQ_STAGES + 1;

  localparam int OUT_LAT = 15 + 2 * DIV_LAT + SQ_LAT;

  function automatic qs_t mulq(q_t a, q_t b);
    logic [2*VW-1:0] p;
    qs_t r;
    p = {{VW{1'b0}}, a} * {{VW{1'b0}}, b};
    r.sat = |p[2*VW-1:VW+FRAC_BITS];
    r.v   = r.sat ? LIM : p[VW+FRAC_BITS-1:FRAC_BITS];
    return r;
  endfunction

  function automatic qs_t addq(q_t a, q_t b);
    logic [VW:0] s;
    qs_t r;
    s = {1'b0, a} + {1'b0, b};
    r.sat = s[VW];
    r.v   = r.sat ? LIM : s[VW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sedx_div.sv -----
`default_nettype none
module sedx_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  sedx_pkg::q_t   num,
  input  sedx_pkg::q_t   den,
  output logic           out_vld,
  output sedx_pkg::qs_t  quo
);
  import sedx_pkg::*;

  typedef struct packed {
    q_t   rem;
    q_t   d;
    q_t   nb;
    q_t   q;
    logic spec;
    logic spsat;
    q_t   spv;
  } dst_t;

  dst_t                st_r  [DIV_STAGES+1];
  dst_t                nxt   [DIV_STAGES+1];
  logic [DIV_STAGES:0] vld_r;
  logic                zero_d;
  logic                ovf;

  function automatic dst_t div_step(dst_t s);
    dst_t        r;
    logic [VW:0] t;
    r = s;
    for (int j = 0; j < DIV_STEP; j++) begin
      t    = {r.rem, r.nb[VW-1]};
      r.nb = {r.nb[VW-2:0], 1'b0};
      if (t >= {1'b0, r.d}) begin
        t   = t - {1'b0, r.d};
        r.q = {r.q[VW-2:0], 1'b1};
      end else begin
        r.q = {r.q[VW-2:0], 1'b0};
      end
      r.rem = t[VW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    zero_d = (den == '0);
    ovf    = {{(VW-FRAC_BITS){1'b0}}, num} >= {den, {(VW-FRAC_BITS){1'b0}}};
    nxt[0].spec  = zero_d | ovf;
    nxt[0].spsat = !(zero_d && (num == '0));
    nxt[0].spv   = nxt[0].spsat ? LIM : '0;
    nxt[0].rem   = q_t'(num >> (VW - FRAC_BITS));
    nxt[0].nb    = {num[VW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    nxt[0].d     = den;
    nxt[0].q     = '0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      nxt[k] = div_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      st_r[k] <= nxt[k];
    end
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STAGES-1:0], in_vld};
    end
  end

  assign out_vld = vld_r[DIV_STAGES];
  assign quo.v   = st_r[DIV_STAGES].spec ? st_r[DIV_STAGES].spv : st_r[DIV_STAGES].q;
  assign quo.sat = st_r[DIV_STAGES].spec & st_r[DIV_STAGES].spsat;

endmodule
`default_nettype wire

// ----- rtl/sedx_sqrt.sv -----
`default_nettype none
module sedx_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  sedx_pkg::q_t  x,
  output logic          out_vld,
  output sedx_pkg::q_t  root
);
  import sedx_pkg::*;

  typedef struct packed {
    logic [2*SQ_RW-1:0] op;
    logic [SQ_RW+1:0]   rem;
    logic [SQ_RW-1:0]   rt;
  } sst_t;

  sst_t               st_r  [SQ_STAGES+1];
  sst_t               nxt   [SQ_STAGES+1];
  logic [SQ_STAGES:0] vld_r;

  function automatic sst_t sq_step(sst_t s);
    sst_t             r;
    logic [SQ_RW+1:0] rn;
    logic [SQ_RW+1:0] tr;
    r = s;
    for (int j = 0; j < SQ_STEP; j++) begin
      rn   = {r.rem[SQ_RW-1:0], r.op[2*SQ_RW-1 -: 2]};
      tr   = {r.rt, 2'b01};
      r.op = {r.op[2*SQ_RW-3:0], 2'b00};
      if (rn >= tr) begin
        r.rem = rn - tr;
        r.rt  = {r.rt[SQ_RW-2:0], 1'b1};
      end else begin
        r.rem = rn;
        r.rt  = {r.rt[SQ_RW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_comb begin
    nxt[0].op  = (2*SQ_RW)'({x, {FRAC_BITS{1'b0}}});
    nxt[0].rem = '0;
    nxt[0].rt  = '0;
    for (int k = 1; k <= SQ_STAGES; k++) begin
      nxt[k] = sq_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= SQ_STAGES; k++) begin
      st_r[k] <= nxt[k];
    end
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQ_STAGES-1:0], in_vld};
    end
  end

  assign out_vld = vld_r[SQ_STAGES];
  assign root    = q_t'(st_r[SQ_STAGES].rt);

endmodule
`default_nettype wire

// ----- rtl/sediment_exchange_source_term.sv -----
// Sediment exchange source term, one grid cell per request.
// Configuration: write cfg_data to register cfg_index while cfg_we is high; the
// write takes effect at that clock edge. Write only while no request is in flight.
// Request: drive the cell fields on the in_ ports and raise start; the request is
// taken at each edge where start is high and busy is low. busy is high only while
// rst_n is held low, so a new request may enter every cycle.
// Result: out_source_rate and out_saturated are shown for one cycle with out_valid
// high. Results leave in request order, one per request, at up to one per cycle.
// A request passes through the input register, five multiply/add stages, a
// 14-stage divider, one subtract stage, a 15-stage square root, three more stages,
// a second 14-stage divider, four add/multiply stages and the output register.
// Reset clears all valid bits and loads the register defaults; requests in
// flight are dropped. The receiver cannot hold results off.
`default_nettype none
module sediment_exchange_source_term (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sedx_pkg::REG_IW-1:0]      cfg_index,
  input  logic [sedx_pkg::IW-1:0]          cfg_data,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_mode,
  input  logic [sedx_pkg::IW-1:0]          in_settling_velocity,
  input  logic [sedx_pkg::IW-1:0]          in_stratification,
  input  logic [sedx_pkg::CW-1:0]          in_concentration,
  input  logic [sedx_pkg::IW-1:0]          in_friction_factor,
  input  logic [sedx_pkg::IW-1:0]          in_flow_speed,
  input  logic [sedx_pkg::IW-1:0]          in_water_depth,
  input  logic [sedx_pkg::IW-1:0]          in_shear_velocity,
  output logic                             out_valid,
  output logic signed [sedx_pkg::OW-1:0]   out_source_rate,
  output logic                             out_saturated
);
  import sedx_pkg::*;

  typedef struct packed {
    logic vld;
    logic mode;
    logic sat;
    logic hk;
    logic ero;
    logic dep;
    logic neg;
    q_t   ws;
    q_t   zf;
    q_t   fs;
    q_t   fw;
    q_t   v;
    q_t   h;
    q_t   uf;
    q_t   v2;
    q_t   t1;
    q_t   tob;
    q_t   thr;
    q_t   hd;
    q_t   m1;
    q_t   a1;
    q_t   u2;
    q_t   r2;
    q_t   zz;
    q_t   g5;
    q_t   z2;
    q_t   ga;
    q_t   gam;
    q_t   g;
    q_t   txn;
    q_t   da;
    q_t   db;
    q_t   x;
    q_t   pp;
    q_t   y;
    q_t   z;
  } item_t;

  logic [IW-1:0] cfg_r [NREG];

  item_t s0_r, s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s8_r, s9_r, s10_r;
  item_t s11_r, s12_r, s13_r, s14_r;
  item_t s0_nxt, s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, sq_nxt;
  item_t s8_nxt, s9_nxt, s10_nxt, s11_nxt, s12_nxt, s13_nxt, s14_nxt;
  item_t d1_r [DIV_LAT];
  item_t d2_r [SQ_LAT];
  item_t d3_r [DIV_LAT];

  logic              div1_vld, div2_vld, sq_vld;
  qs_t               quo1, quo2;
  q_t                sq_root;
  logic              out_valid_r, out_saturated_r, out_saturated_nxt;
  logic [OW-1:0]     out_rate_r, out_rate_nxt;

  qs_t  m_a, m_b, m_c, m_d, m_e, m_f, m_g, m_h, m_k, m_l, m_p, m_y, m_y2, m_den;
  qs_t  m_cc, m_beta, m_12, m_13, m_14;
  logic g_act8, g_act9;
  q_t   mag;

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) begin
        if (i == int'(REG_ERO_BASE) || i == int'(REG_DEP_STRESS)
            || i == int'(REG_UCR)) begin
          cfg_r[i] <= IW'(Q_ONE);
        end else begin
          cfg_r[i] <= '0;
        end
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // capture
  always_comb begin
    s0_nxt      = '0;
    s0_nxt.vld  = start & ~busy;
    s0_nxt.mode = in_mode;
    s0_nxt.ws   = q_t'(in_settling_velocity);
    s0_nxt.zf   = q_t'(in_stratification);
    s0_nxt.fs   = q_t'(in_concentration);
    s0_nxt.fw   = q_t'(in_friction_factor);
    s0_nxt.v    = q_t'(in_flow_speed);
    s0_nxt.h    = q_t'(in_water_depth);
    s0_nxt.uf   = q_t'(in_shear_velocity);
  end

  always_comb begin
    s1_nxt = s0_r;
    m_a = mulq(s0_r.v, s0_r.v);
    m_b = mulq(s0_r.uf, s0_r.uf);
    m_c = mulq(q_t'(cfg_r[REG_UCR]), q_t'(cfg_r[REG_UCR]));
    m_d = mulq(s0_r.zf, s0_r.zf);
    m_e = mulq(Q_5975, s0_r.zf);
    s1_nxt.hk  = s0_r.h > q_t'(cfg_r[REG_KNEE]);
    s1_nxt.hd  = s0_r.h - q_t'(cfg_r[REG_KNEE]);
    s1_nxt.v2  = m_a.v;
    s1_nxt.u2  = m_b.v;
    s1_nxt.r2  = m_c.v;
    s1_nxt.zz  = m_d.v;
    s1_nxt.g5  = m_e.v;
    s1_nxt.sat = s0_r.mode ? m_a.sat : (m_b.sat | m_c.sat | m_d.sat | m_e.sat);
  end

  always_comb begin
    s2_nxt = s1_r;
    m_f = mulq(s1_r.fw, s1_r.v2);
    m_g = mulq(q_t'(cfg_r[REG_SLOPE]), s1_r.hd);
    m_h = mulq(Q_2888, s1_r.zz);
    m_k = addq(Q_434, s1_r.g5);
    s2_nxt.t1  = m_f.v;
    s2_nxt.m1  = m_g.v;
    s2_nxt.z2  = m_h.v;
    s2_nxt.ga  = m_k.v;
    s2_nxt.sat = s1_r.sat | (s1_r.mode ? (m_f.sat | (s1_r.hk & m_g.sat))
                                       : (m_h.sat | m_k.sat));
  end

  always_comb begin
    qs_t m_tob, a_a1, a_gam;
    s3_nxt = s2_r;
    m_tob = mulq(q_t'(cfg_r[REG_RHO]), s2_r.t1);
    a_a1  = addq(Q_ONE, s2_r.m1);
    a_gam = addq(s2_r.ga, s2_r.z2);
    s3_nxt.tob = m_tob.v;
    s3_nxt.a1  = a_a1.v;
    s3_nxt.gam = a_gam.v;
    s3_nxt.sat = s2_r.sat | (s2_r.mode ? (m_tob.sat | (s2_r.hk & a_a1.sat)) : a_gam.sat);
  end

  always_comb begin
    qs_t m_thr, m_gg;
    s4_nxt = s3_r;
    m_thr = mulq(q_t'(cfg_r[REG_ERO_BASE]), s3_r.a1);
    m_gg  = mulq(s3_r.gam, s3_r.fs);
    s4_nxt.thr = s3_r.hk ? m_thr.v : q_t'(cfg_r[REG_ERO_BASE]);
    s4_nxt.g   = m_gg.v;
    s4_nxt.txn = (s3_r.u2 > s3_r.r2) ? (s3_r.u2 - s3_r.r2) : '0;
    s4_nxt.sat = s3_r.sat | (s3_r.mode ? (s3_r.hk & m_thr.sat) : m_gg.sat);
  end

  always_comb begin
    s5_nxt = s4_r;
    m_l = mulq(q_t'(cfg_r[REG_ERO_RATIO]), s4_r.tob - s4_r.thr);
    s5_nxt.ero = s4_r.tob > s4_r.thr;
    s5_nxt.dep = !(s4_r.tob > s4_r.thr) && (s4_r.tob < q_t'(cfg_r[REG_DEP_STRESS]));
    if (s4_r.mode) begin
      if (s5_nxt.ero) begin
        s5_nxt.da = m_l.v;
        s5_nxt.db = s4_r.thr;
      end else if (s5_nxt.dep) begin
        s5_nxt.da = s4_r.tob;
        s5_nxt.db = q_t'(cfg_r[REG_DEP_STRESS]);
      end else begin
        s5_nxt.da = '0;
        s5_nxt.db = Q_ONE;
      end
    end else begin
      s5_nxt.da = s4_r.txn;
      s5_nxt.db = s4_r.r2;
    end
    s5_nxt.sat = s4_r.sat | (s4_r.mode & s5_nxt.ero & m_l.sat);
  end

  sedx_div u_div1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s5_r.vld),
    .num     (s5_r.da),
    .den     (s5_r.db),
    .out_vld (div1_vld),
    .quo     (quo1)
  );

  always_comb begin
    s6_nxt = d1_r[DIV_LAT-1];
    s6_nxt.sat = d1_r[DIV_LAT-1].sat | quo1.sat;
    s6_nxt.x   = (d1_r[DIV_LAT-1].mode & d1_r[DIV_LAT-1].dep) ? (Q_ONE - quo1.v) : quo1.v;
  end

  always_comb begin
    sq_nxt = s6_r;
    m_p = mulq(s6_r.x, s6_r.x);
    sq_nxt.pp  = m_p.v;
    sq_nxt.sat = s6_r.sat | (s6_r.mode & s6_r.dep & m_p.sat);
  end

  sedx_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s6_r.vld),
    .x       (s6_r.x),
    .out_vld (sq_vld),
    .root    (sq_root)
  );

  always_comb begin
    s8_nxt = d2_r[SQ_LAT-1];
    g_act8 = d2_r[SQ_LAT-1].mode ? d2_r[SQ_LAT-1].dep : 1'b1;
    m_y = mulq(d2_r[SQ_LAT-1].mode ? d2_r[SQ_LAT-1].pp : d2_r[SQ_LAT-1].x, sq_root);
    s8_nxt.y   = m_y.v;
    s8_nxt.sat = d2_r[SQ_LAT-1].sat | (g_act8 & m_y.sat);
  end

  always_comb begin
    s9_nxt = s8_r;
    g_act9 = s8_r.mode ? s8_r.dep : 1'b1;
    m_y2 = mulq(s8_r.mode ? Q_19_4 : q_t'(cfg_r[REG_PICKUP]), s8_r.y);
    s9_nxt.y   = m_y2.v;
    s9_nxt.sat = s8_r.sat | (g_act9 & m_y2.sat);
  end

  always_comb begin
    s10_nxt = s9_r;
    m_den = addq(Q_5_4, s9_r.y);
    m_cc  = mulq(Q_3_10, s9_r.y);
    if (s9_r.mode) begin
      s10_nxt.da = s9_r.dep ? s9_r.zf : '0;
      s10_nxt.db = s9_r.dep ? m_den.v : Q_ONE;
    end else begin
      s10_nxt.da = m_cc.v;
      s10_nxt.db = s9_r.h;
    end
    s10_nxt.sat = s9_r.sat | (s9_r.mode ? (s9_r.dep & m_den.sat) : m_cc.sat);
  end

  sedx_div u_div2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s10_r.vld),
    .num     (s10_r.da),
    .den     (s10_r.db),
    .out_vld (div2_vld),
    .quo     (quo2)
  );

  always_comb begin
    s11_nxt = d3_r[DIV_LAT-1];
    m_beta = addq(Q_ONE, quo2.v);
    if (d3_r[DIV_LAT-1].mode) begin
      s11_nxt.z   = m_beta.v;
      s11_nxt.neg = d3_r[DIV_LAT-1].dep;
    end else begin
      s11_nxt.neg = d3_r[DIV_LAT-1].g > quo2.v;
      s11_nxt.z   = s11_nxt.neg ? (d3_r[DIV_LAT-1].g - quo2.v) : (quo2.v - d3_r[DIV_LAT-1].g);
    end
    s11_nxt.sat = d3_r[DIV_LAT-1].sat | quo2.sat
                | (d3_r[DIV_LAT-1].mode & d3_r[DIV_LAT-1].dep & m_beta.sat);
  end

  always_comb begin
    s12_nxt = s11_r;
    m_12 = mulq(s11_r.mode ? s11_r.fs : s11_r.ws, s11_r.z);
    s12_nxt.z   = m_12.v;
    s12_nxt.sat = s11_r.sat | ((s11_r.mode ? s11_r.dep : 1'b1) & m_12.sat);
  end

  always_comb begin
    s13_nxt = s12_r;
    m_13 = mulq(s12_r.ws, s12_r.z);
    if (s12_r.mode) begin
      s13_nxt.z   = m_13.v;
      s13_nxt.sat = s12_r.sat | (s12_r.dep & m_13.sat);
    end
  end

  always_comb begin
    s14_nxt = s13_r;
    m_14 = mulq(s13_r.z, s13_r.x);
    if (s13_r.mode) begin
      s14_nxt.z   = m_14.v;
      s14_nxt.sat = s13_r.sat | (s13_r.dep & m_14.sat);
    end
  end

  always_comb begin
    if (s14_r.mode) begin
      mag = s14_r.ero ? s14_r.x : (s14_r.dep ? s14_r.z : '0);
    end else begin
      mag = s14_r.z;
    end
    out_saturated_nxt = s14_r.sat;
    if (!s14_r.neg) begin
      if (mag > q_t'(32'h7FFF_FFFF)) begin
        out_saturated_nxt = 1'b1;
        out_rate_nxt      = 32'h7FFF_FFFF;
      end else begin
        out_rate_nxt = mag[OW-1:0];
      end
    end else begin
      if (mag > q_t'(33'h0_8000_0000)) begin
        out_saturated_nxt = 1'b1;
        out_rate_nxt      = 32'h8000_0000;
      end else begin
        out_rate_nxt = 32'd0 - mag[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r  <= '0;
      s1_r  <= '0;
      s2_r  <= '0;
      s3_r  <= '0;
      s4_r  <= '0;
      s5_r  <= '0;
      s6_r  <= '0;
      s8_r  <= '0;
      s9_r  <= '0;
      s10_r <= '0;
      s11_r <= '0;
      s12_r <= '0;
      s13_r <= '0;
      s14_r <= '0;
      for (int k = 0; k < DIV_LAT; k++) begin
        d1_r[k] <= '0;
        d3_r[k] <= '0;
      end
      for (int k = 0; k < SQ_LAT; k++) begin
        d2_r[k] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      s0_r  <= s0_nxt;
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      s5_r  <= s5_nxt;
      s6_r  <= s6_nxt;
      s8_r  <= s8_nxt;
      s9_r  <= s9_nxt;
      s10_r <= s10_nxt;
      s11_r <= s11_nxt;
      s12_r <= s12_nxt;
      s13_r <= s13_nxt;
      s14_r <= s14_nxt;
      d1_r[0] <= s5_r;
      d3_r[0] <= s10_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        d1_r[k] <= d1_r[k-1];
        d3_r[k] <= d3_r[k-1];
      end
      d2_r[0] <= sq_nxt;
      for (int k = 1; k < SQ_LAT; k++) begin
        d2_r[k] <= d2_r[k-1];
      end
      out_valid_r <= s14_r.vld;
    end
    out_rate_r      <= out_rate_nxt;
    out_saturated_r <= out_saturated_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_source_rate = out_rate_r;
  assign out_saturated   = out_saturated_r;

  a_out_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, OUT_LAT))
    else $error("result without a matching request");

  a_div1_align: assert property (@(posedge clk) disable iff (!rst_n)
    div1_vld == d1_r[DIV_LAT-1].vld)
    else $error("first divider out of step with its request");

  a_sqrt_align: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld == d2_r[SQ_LAT-1].vld)
    else $error("square root out of step with its request");

  a_div2_align: assert property (@(posedge clk) disable iff (!rst_n)
    div2_vld == d3_r[DIV_LAT-1].vld)
    else $error("second divider out of step with its request");

endmodule
`default_nettype wire
